[rtl/direct_mapped_icache_defines.svh]
// ---------------------------------------------------------------------------
// Direct-mapped instruction cache: assertion macros
// Shared property wrappers for the cache checker, clocked on clk_i and
// disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_ICACHE_DEFINES_SVH
`define DIRECT_MAPPED_ICACHE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DMIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DMIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`define DMIC_ASSERT_LAT2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

[rtl/dmic_pkg.sv]
// ---------------------------------------------------------------------------
// Direct-mapped instruction cache package
// Geometry constants, command and register codes, beat types.
// ---------------------------------------------------------------------------
package dmic_pkg;

  // Number of cache entries; must be a power of two between 2 and 4096.
  localparam int Entries = 64;
  localparam int IdxW    = $clog2(Entries);
  localparam int AddrW   = 32;
  localparam int DataW   = 32;
  localparam int WordW   = 16;
  localparam int TagLsb  = 8;
  localparam int TagW    = AddrW - TagLsb;
  localparam int IdxLsb  = 2;
  localparam int LineW   = TagW + DataW;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_FILL   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic {
    REG_ENABLE = 1'b0,
    REG_FREEZE = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    S_IDLE,
    S_LOOK
  } state_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] fill_data;
    logic             clear_all;
    logic             clear_entry;
  } dmic_req_t;

  typedef struct packed {
    logic             hit;
    logic [WordW-1:0] word;
  } dmic_rsp_t;

  // Update request for the valid-bit array.
  typedef struct packed {
    logic            set;
    logic            clr_one;
    logic            clr_all;
    logic [IdxW-1:0] idx;
  } dmic_vld_op_t;

endpackage

[rtl/dmic_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module dmic_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/dmic_valid.sv]
// ---------------------------------------------------------------------------
// Valid-bit array
// One flip-flop per entry, cleared at reset; supports set, single clear and
// flash clear of every entry.
// ---------------------------------------------------------------------------
module dmic_valid import dmic_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  dmic_vld_op_t op_i,
  output logic         valid_o
);

  logic [Entries-1:0] valid_q;
  logic [Entries-1:0] valid_d;

  always_comb begin
    valid_d = valid_q;
    if (op_i.clr_all) begin
      valid_d = '0;
    end else if (op_i.clr_one) begin
      valid_d[op_i.idx] = 1'b0;
    end
    if (op_i.set) begin
      valid_d[op_i.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign valid_o = valid_q[op_i.idx];

endmodule

[rtl/direct_mapped_icache.sv]
// ---------------------------------------------------------------------------
// Direct-mapped instruction cache
// 64-entry read-only long-word cache with lookup, fill and clear commands.
// ---------------------------------------------------------------------------
// Usage:
//   Request beats arrive on in_valid_i / in_stall_o with in_data_i; every
//   request yields exactly one response beat on out_valid_o / out_stall_i
//   with out_data_o (hit and selected 16-bit word; zero for fill, clear and
//   misses). Enable and freeze are written over cfg_valid_i / cfg_ready_o,
//   which is always ready; write them only while no request is in flight.
//   The tag and data memory is read in the cycle of acceptance, and in the
//   following cycle the tag is compared, the entry is updated and the
//   response register is loaded, from which the response beat is presented.
//   No request is accepted during that lookup, so a new request is taken
//   only once the last has been looked up, set by the read-modify-write of
//   the single tag/data memory. At reset all valid bits, enable and freeze
//   are cleared at once; no clearing pass is needed. While the receiver
//   stalls, the response is held and no further request is accepted until
//   it has been taken.
// ---------------------------------------------------------------------------
module direct_mapped_icache import dmic_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dmic_req_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output dmic_rsp_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  cfg_reg_e  cfg_index_i,
  input  logic      cfg_data_i
);

  state_e       state_q, state_d;
  dmic_req_t    req_q;
  dmic_rsp_t    rsp_q, rsp_d;
  logic         out_valid_q, out_valid_d;
  logic         enable_q, freeze_q;
  logic         in_accept, look_phase;
  logic         ram_we;
  logic [LineW-1:0] ram_rdata;
  logic [IdxW-1:0]  req_idx, in_idx;
  logic [TagW-1:0]  req_tag, line_tag;
  logic [DataW-1:0] line_data;
  logic         line_valid, tag_match;
  dmic_vld_op_t vld_op;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      freeze_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ENABLE: enable_q <= cfg_data_i;
        REG_FREEZE: freeze_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_accept) state_d = S_LOOK;
      S_LOOK:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // State outputs. A request is only taken once the response register is
  // free or being emptied, so the lookup cycle can always load it.
  always_comb begin
    in_stall_o = 1'b1;
    look_phase = 1'b0;
    case (state_q)
      S_IDLE:  in_stall_o = out_valid_q && out_stall_i;
      S_LOOK:  look_phase = 1'b1;
      default: in_stall_o = 1'b1;
    endcase
  end

  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_data_i;
    end
  end

  assign in_idx  = in_data_i.addr[IdxLsb +: IdxW];
  assign req_idx = req_q.addr[IdxLsb +: IdxW];
  assign req_tag = req_q.addr[AddrW-1:TagLsb];

  assign line_tag  = ram_rdata[LineW-1:DataW];
  assign line_data = ram_rdata[DataW-1:0];

  assign ram_we = look_phase && (req_q.cmd == CMD_FILL) && enable_q && !freeze_q;

  dmic_ram #(
    .Width (LineW),
    .Depth (Entries)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (req_idx),
    .wdata_i ({req_tag, req_q.fill_data}),
    .re_i    (in_accept),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  assign tag_match = line_valid && (line_tag == req_tag);

  always_comb begin
    vld_op         = '0;
    vld_op.idx     = req_idx;
    vld_op.set     = ram_we;
    vld_op.clr_all = look_phase && (req_q.cmd == CMD_CLEAR) && req_q.clear_all;
    vld_op.clr_one = look_phase && (req_q.cmd == CMD_CLEAR) && req_q.clear_entry
                     && tag_match;
  end

  dmic_valid u_valid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (vld_op),
    .valid_o (line_valid)
  );

  // Address bit 1 clear selects the upper half of the long word.
  always_comb begin
    rsp_d = '0;
    if ((req_q.cmd == CMD_LOOKUP) && enable_q && tag_match) begin
      rsp_d.hit  = 1'b1;
      rsp_d.word = req_q.addr[1] ? line_data[WordW-1:0] : line_data[DataW-1:WordW];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (look_phase) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (look_phase) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

endmodule

[rtl/dmic_chk.sv]
// ---------------------------------------------------------------------------
// Direct-mapped instruction cache checker
// Port-level assertions on response timing and content, bound to the top.
// ---------------------------------------------------------------------------
`include "direct_mapped_icache_defines.svh"

module dmic_chk import dmic_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input dmic_req_t in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input dmic_rsp_t out_data_o,
  input logic      cfg_valid_i,
  input logic      cfg_ready_o
);

  logic in_beat;
  logic cfg_beat;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign cfg_beat = cfg_valid_i && cfg_ready_o;

  // A stalled response beat stays put.
  `DMIC_ASSERT_NEXT(a_rsp_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "response changed while stalled")

  // A miss always carries a zero word.
  `DMIC_ASSERT_NOW(a_miss_zero, out_valid_o && !out_data_o.hit, out_data_o.word == '0, "miss with non-zero word")

  // Only one request is in flight, and its response slot is empty meanwhile.
  `DMIC_ASSERT_NEXT(a_one_in_flight, in_beat, in_stall_o && !out_valid_o, "second request or stale response during lookup")

  // Anything but a lookup answers with a miss.
  `DMIC_ASSERT_LAT2(a_non_lookup_miss, in_beat && (in_data_i.cmd != CMD_LOOKUP), out_valid_o && !out_data_o.hit, "non-lookup command reported a hit")

  // The configuration port never pushes back.
  `DMIC_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_beat, "configuration write refused")

endmodule

bind direct_mapped_icache dmic_chk u_dmic_chk (.*);
